// File: design/stag_pkg.sv
// shared types and constants for the strided tensor address generator
package stag_pkg;

    // field widths
    localparam int IDX_W        = 48;
    localparam int EXT_W        = 32;
    localparam int STR_W        = 48;
    localparam int ESIZE_W      = 16;
    localparam int RANK_W       = 4;
    localparam int AXIS_W       = 3;
    localparam int ADDR_BITS    = 48;
    localparam int SUM_W        = ADDR_BITS + 1;
    localparam int RANK_CMP_W   = 5;

    // stream and configuration widths
    localparam int S_TDATA_W    = 136;
    localparam int M_TDATA_W    = 96;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 48;

    // default table depth
    localparam int MAX_RANK_DEF = 8;

    // divider step counter width
    localparam int DIV_CNT_W    = $clog2(IDX_W + 1);

    // input item kinds
    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_XLATE = 1'b1
    } t_func;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANK     = 3'd0,
        CFG_ESIZE    = 3'd1,
        CFG_OFFSET   = 3'd2,
        CFG_COUNT    = 3'd3,
        CFG_SRC_BASE = 3'd4,
        CFG_DST_BASE = 3'd5
    } t_cfg_reg;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DIV,
        ST_MUL_AX,
        ST_SRC_MUL,
        ST_SRC_BASE,
        ST_SRC_OFF,
        ST_DST_MUL,
        ST_DST_BASE,
        ST_DONE
    } t_state;

endpackage

// File: design/strided_tensor_address_generator_unit.sv
// strided tensor address generator: axis table, sequencer and shared adder
//
//  channel   direction  fields (lowest bit first)
//  i_s_*     in         tuser: func; tdata: axis, axis_extent, axis_stride, element_index
//  o_m_*     out        tdata: source_address, dest_address
//  i_cfg_*   in         index, data (register write, always ready)
//
// a translate runs, for each axis in use, a table fetch, a divide and a multiply-accumulate,
// then scales by the element size and adds the source base and offset; the destination
// is its base plus the scaled index. the pace is set by the single 49-bit adder, which
// does one divider bit a cycle over the 48-bit index or one multiplier bit a cycle over up to 32 bits.
// reset is synchronous and clears control and configuration, not the axis table.
// a finished result waits in the output register; a new item is accepted meanwhile.
module strided_tensor_address_generator_unit
    import stag_pkg::*;
#(
    parameter int MAX_RANK = MAX_RANK_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,  // axis, axis_extent, axis_stride, element_index
    input  logic                  i_s_tuser,  // func
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata   // source_address, dest_address
);

    localparam int TAB_W = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(IDX_W - 1);

    // configuration registers
    logic [RANK_W-1:0]    r_rank;
    logic [ESIZE_W-1:0]   r_esize;
    logic [ADDR_BITS-1:0] r_offset;
    logic [IDX_W-1:0]     r_count;
    logic [ADDR_BITS-1:0] r_sbase;
    logic [ADDR_BITS-1:0] r_dbase;

    // axis table and its registered read
    logic [EXT_W-1:0]     r_ext_mem [MAX_RANK];
    logic [STR_W-1:0]     r_str_mem [MAX_RANK];
    logic [EXT_W-1:0]     r_ext_q;
    logic [STR_W-1:0]     r_str_q;

    // sequencer and datapath registers
    t_state               r_state, n_state;
    logic [TAB_W-1:0]     r_axis, n_axis;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [IDX_W-1:0]     r_quot, n_quot;
    logic [EXT_W-1:0]     r_part, n_part;
    logic [ADDR_BITS-1:0] r_acc, n_acc;
    logic [ADDR_BITS-1:0] r_mcand, n_mcand;
    logic [EXT_W-1:0]     r_mplier, n_mplier;
    logic [ADDR_BITS-1:0] r_src, n_src;
    logic                 r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;

    // input field unpacking
    logic                 s_accept;
    t_func                in_func;
    logic [AXIS_W-1:0]    in_axis;
    logic [EXT_W-1:0]     in_extent;
    logic [STR_W-1:0]     in_stride;
    logic [IDX_W-1:0]     in_index;
    logic [RANK_CMP_W-1:0] ld_axis;
    logic                 ld_ok;

    // shared adder
    logic [ADDR_BITS-1:0] u_a, u_b;
    logic                 u_sub;
    logic [SUM_W-1:0]     u_sum;
    logic                 u_carry;

    // misc control
    logic [RANK_CMP_W-1:0] used, first_axis;
    logic [EXT_W:0]        div_shift;
    logic                  out_free;
    logic                  in_range;

    assign s_accept   = i_s_tvalid && o_s_tready;
    assign in_func    = t_func'(i_s_tuser);
    assign in_axis    = i_s_tdata[2:0];
    assign in_extent  = i_s_tdata[34:3];
    assign in_stride  = i_s_tdata[82:35];
    assign in_index   = i_s_tdata[130:83];
    assign ld_axis    = RANK_CMP_W'(in_axis);
    assign ld_ok      = ld_axis < RANK_CMP_W'(MAX_RANK);

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;

    // rank saturated to the table depth
    assign used       = (RANK_CMP_W'(r_rank) > RANK_CMP_W'(MAX_RANK)) ?
                        RANK_CMP_W'(MAX_RANK) : RANK_CMP_W'(r_rank);
    assign first_axis = used - RANK_CMP_W'(1);

    assign div_shift  = {r_part, r_quot[IDX_W-1]};
    assign out_free   = !r_m_valid || i_m_tready;

    // shared add / subtract unit, carry out means a >= b when subtracting
    assign u_sum    = {1'b0, u_a} + {1'b0, (u_sub ? ~u_b : u_b)} + SUM_W'(u_sub);
    assign u_carry  = u_sum[SUM_W-1];
    assign in_range = !u_carry;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank   <= RANK_W'(1);
            r_esize  <= ESIZE_W'(1);
            r_offset <= '0;
            r_count  <= '0;
            r_sbase  <= '0;
            r_dbase  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_RANK:     r_rank   <= i_cfg_data[RANK_W-1:0];
                CFG_ESIZE:    r_esize  <= i_cfg_data[ESIZE_W-1:0];
                CFG_OFFSET:   r_offset <= i_cfg_data[ADDR_BITS-1:0];
                CFG_COUNT:    r_count  <= i_cfg_data[IDX_W-1:0];
                CFG_SRC_BASE: r_sbase  <= i_cfg_data[ADDR_BITS-1:0];
                CFG_DST_BASE: r_dbase  <= i_cfg_data[ADDR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // axis table write on load transfers, registered read at the axis pointer
    always_ff @(posedge i_clk) begin
        if (s_accept && in_func == FUNC_LOAD && ld_ok) begin
            r_ext_mem[ld_axis[TAB_W-1:0]] <= in_extent;
            r_str_mem[ld_axis[TAB_W-1:0]] <= in_stride;
        end
        r_ext_q <= r_ext_mem[r_axis];
        r_str_q <= r_str_mem[r_axis];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept && in_func == FUNC_XLATE && in_range) begin
                    n_state = (used == '0) ? ST_SRC_MUL : ST_FETCH;
                end
            end
            ST_FETCH:    n_state = ST_DIV;
            ST_DIV: begin
                if (r_ext_q == '0 || r_cnt == DIV_LAST) begin
                    n_state = ST_MUL_AX;
                end
            end
            ST_MUL_AX: begin
                if (r_mplier == '0) begin
                    n_state = (r_axis == '0) ? ST_SRC_MUL : ST_FETCH;
                end
            end
            ST_SRC_MUL: begin
                if (r_mplier == '0) begin
                    n_state = ST_SRC_BASE;
                end
            end
            ST_SRC_BASE: n_state = ST_SRC_OFF;
            ST_SRC_OFF:  n_state = ST_DST_MUL;
            ST_DST_MUL: begin
                if (r_mplier == '0) begin
                    n_state = ST_DST_BASE;
                end
            end
            ST_DST_BASE: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // datapath control and adder operands
    always_comb begin
        n_axis   = r_axis;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_quot   = r_quot;
        n_part   = r_part;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_src    = r_src;
        u_a      = r_acc;
        u_b      = r_mcand;
        u_sub    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // range check of the incoming index against the element count
                u_a      = in_index;
                u_b      = r_count;
                u_sub    = 1'b1;
                n_idx    = in_index;
                n_quot   = in_index;
                n_part   = '0;
                n_cnt    = '0;
                n_acc    = '0;
                n_axis   = first_axis[TAB_W-1:0];
                n_mcand  = '0;
                n_mplier = EXT_W'(r_esize);
            end
            ST_DIV: begin
                // one restoring divider bit per cycle
                u_a   = ADDR_BITS'(div_shift);
                u_b   = ADDR_BITS'(r_ext_q);
                u_sub = 1'b1;
                if (r_ext_q == '0) begin
                    n_mplier = '0;
                end else begin
                    n_part   = u_carry ? u_sum[EXT_W-1:0] : div_shift[EXT_W-1:0];
                    n_quot   = {r_quot[IDX_W-2:0], u_carry};
                    n_cnt    = r_cnt + DIV_CNT_W'(1);
                    n_mplier = n_part;
                    n_mcand  = r_str_q;
                end
            end
            ST_MUL_AX, ST_SRC_MUL, ST_DST_MUL: begin
                // one shift-add multiplier bit per cycle
                if (r_mplier != '0) begin
                    if (r_mplier[0]) begin
                        n_acc = u_sum[ADDR_BITS-1:0];
                    end
                    n_mplier = r_mplier >> 1;
                    n_mcand  = r_mcand << 1;
                end else if (r_state == ST_MUL_AX) begin
                    n_part = '0;
                    n_cnt  = '0;
                    if (r_axis == '0) begin
                        n_mcand  = r_acc;
                        n_acc    = '0;
                        n_mplier = EXT_W'(r_esize);
                    end else begin
                        n_axis = r_axis - TAB_W'(1);
                    end
                end
            end
            ST_SRC_BASE: begin
                u_b   = r_sbase;
                n_acc = u_sum[ADDR_BITS-1:0];
            end
            ST_SRC_OFF: begin
                u_b      = r_offset;
                n_src    = u_sum[ADDR_BITS-1:0];
                n_acc    = '0;
                n_mcand  = r_idx;
                n_mplier = EXT_W'(r_esize);
            end
            ST_DST_BASE: begin
                u_b   = r_dbase;
                n_acc = u_sum[ADDR_BITS-1:0];
            end
            default: ;
        endcase
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_axis   <= n_axis;
        r_cnt    <= n_cnt;
        r_idx    <= n_idx;
        r_quot   <= n_quot;
        r_part   <= n_part;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_src    <= n_src;
    end

    // output register, source address in the low half
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_m_data <= {r_acc, r_src};
        end
    end

    // divider remainder stays below a non-zero extent
    a_div_part: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_ext_q != '0) |-> (r_part < r_ext_q))
        else $error("divider remainder not below extent");

    // table reads stay inside the table
    a_fetch_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |-> (RANK_CMP_W'(r_axis) < RANK_CMP_W'(MAX_RANK)))
        else $error("axis pointer beyond table");

    // a translate within range starts the sequence
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && in_func == FUNC_XLATE && in_index < r_count)
        |=> (r_state == ST_FETCH || r_state == ST_SRC_MUL))
        else $error("in-range translate did not start");

    // a dropped or load transfer leaves the block ready
    a_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (in_func == FUNC_LOAD || in_index >= r_count))
        |=> (r_state == ST_IDLE))
        else $error("load or dropped index started a sequence");

    // leaving the final state always presents a result
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> (o_m_tvalid && r_state == ST_IDLE))
        else $error("finished translate gave no result");

endmodule
